// ===== rtl/core/rdq_pkg.sv =====
// Shared types and codes for the reversible deque.
// Holds operation and status codes, field widths and the cell control struct.
// No dependencies.
package rdq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int ITEM_WIDTH_DEF = 32;

   localparam int OP_W   = 2;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
   localparam logic [OP_W-1:0] OP_REVERSE = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // per-cycle command broadcast to every storage cell
   typedef struct packed {
      logic shift_up;    // push at the front: each cell takes its lower neighbor
      logic shift_down;  // pop at the front: each cell takes its upper neighbor
      logic append;      // push at the back: the cell at the fill level loads the word
   } rdq_cell_ctl_type;

endpackage

// ===== rtl/core/rdq_req_if.sv =====
// Request channel of the reversible deque: valid/ready plus operation payload.
// Depends on rdq_pkg.
interface rdq_req_if;
   import rdq_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic              at_tail;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, output operation, output at_tail, output data_in,
                   input ready);
   modport sink   (input valid, input operation, input at_tail, input data_in,
                   output ready);
endinterface

// ===== rtl/core/rdq_rsp_if.sv =====
// Response channel of the reversible deque: valid/ready plus result payload.
// Depends on rdq_pkg.
interface rdq_rsp_if;
   import rdq_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic [STAT_W-1:0] status;
   logic [OCC_W-1:0]  occupancy;

   modport source (output valid, output data_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input data_out, input status, input occupancy,
                   output ready);
endinterface

// ===== rtl/core/reversible_deque.sv =====
// Reversible deque: a row of storage cells, front always in cell 0, with a reverse flag.
// Response registered the cycle after acceptance; one transaction per cycle sustained
// while the response side keeps taking results; a held response stalls the request side.
// The tail read chain through all DEPTH cells sets the clock period, not the rate.
// Reset clears the fill count, the reverse flag and the response valid; cell contents
// are left as they are and need no clearing pass.
module reversible_deque #(
   parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   rdq_req_if.sink   req_ch,
   rdq_rsp_if.source rsp_ch
);
   import rdq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rev_ff, rev_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic                  accept;
   logic                  back;
   logic                  empty;
   logic                  full;
   logic [ITEM_WIDTH-1:0] word;
   logic [ITEM_WIDTH-1:0] read_word;
   logic [DATA_W-1:0]     read_data;
   logic [OCC_W-1:0]      occ_next;
   rdq_cell_ctl_type      cell_ctl;

   logic [ITEM_WIDTH-1:0] slots [DEPTH];
   logic [ITEM_WIDTH-1:0] taps  [DEPTH+1];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign back         = req_ch.at_tail ^ rev_ff;
   assign empty        = (count_ff == '0);
   assign full         = (count_ff == FULL_CNT);

   generate
      if (ITEM_WIDTH >= DATA_W) begin : g_wide
         assign word      = ITEM_WIDTH'(req_ch.data_in);
         assign read_data = read_word[DATA_W-1:0];
      end else begin : g_narrow
         assign word      = req_ch.data_in[ITEM_WIDTH-1:0];
         assign read_data = DATA_W'(read_word);
      end
      if (CNT_W >= OCC_W) begin : g_occ_trunc
         assign occ_next = count_in[OCC_W-1:0];
      end else begin : g_occ_ext
         assign occ_next = OCC_W'(count_in);
      end
   endgenerate

   assign read_word = back ? taps[DEPTH] : slots[0];

   always_comb begin
      cell_ctl      = '0;
      count_in      = count_ff;
      rev_in        = rev_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = ST_OK;
         case (req_ch.operation)
            OP_PUSH: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cell_ctl.shift_up = !back;
                  cell_ctl.append   = back;
                  count_in          = count_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in         = read_data;
                  cell_ctl.shift_down = !back;
                  count_in            = count_ff - 1'b1;
               end
            end
            OP_PEEK: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in = read_data;
               end
            end
            OP_REVERSE: begin
               rev_in = !rev_ff;
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
         rsp_occ_in = occ_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign taps[0] = '0;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         rdq_cell #(
            .ITEM_WIDTH (ITEM_WIDTH),
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
         ) u_cell (
            .clock     (clock),
            .ctl       (cell_ctl),
            .count     (count_ff),
            .word      (word),
            .prev_data ((i == 0) ? word : slots[(i == 0) ? 0 : i-1]),
            .next_data ((i == DEPTH-1) ? slots[i] : slots[(i == DEPTH-1) ? i : i+1]),
            .tap_in    (taps[i]),
            .slot      (slots[i]),
            .tap_out   (taps[i+1])
         );
      end
   endgenerate

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.data_out  = rsp_data_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.occupancy = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.operation == OP_PUSH) && !full |=>
         count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not grow the deque");

   a_reverse_flips: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.operation == OP_REVERSE) |=> rev_ff != $past(rev_ff))
      else $error("reverse did not flip the orientation");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL || rsp_status_ff == ST_EMPTY) |->
         rsp_data_ff == '0)
      else $error("error response carries data");

endmodule

// ===== rtl/core/rdq_cell.sv =====
// One storage cell of the deque row: holds one word and trades it with its neighbors.
// Also contributes to the tail read chain. Depends on rdq_pkg.
module rdq_cell #(
   parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEF,
   parameter int CNT_W      = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                      clock,
   input  rdq_pkg::rdq_cell_ctl_type ctl,
   input  logic [CNT_W-1:0]          count,
   input  logic [ITEM_WIDTH-1:0]     word,
   input  logic [ITEM_WIDTH-1:0]     prev_data,
   input  logic [ITEM_WIDTH-1:0]     next_data,
   input  logic [ITEM_WIDTH-1:0]     tap_in,
   output logic [ITEM_WIDTH-1:0]     slot,
   output logic [ITEM_WIDTH-1:0]     tap_out
);
   import rdq_pkg::*;

   localparam logic [CNT_W-1:0] SLOT_IDX = CNT_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CELL_INDEX + 1);

   logic [ITEM_WIDTH-1:0] slot_ff;
   logic [ITEM_WIDTH-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.shift_up) begin
         slot_in = prev_data;
      end else if (ctl.shift_down) begin
         slot_in = next_data;
      end else if (ctl.append && (count == SLOT_IDX)) begin
         slot_in = word;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // the cell holding the last word drives the tail chain
   assign tap_out = tap_in | ((count == LAST_CNT) ? slot_ff : '0);
   assign slot    = slot_ff;

endmodule
